[hdl/qvr_pkg.sv]
`default_nettype none

package qvr_pkg;

  // Vector and result components, signed 16-bit integers.
  typedef logic signed [15:0] vec_t;
  // Quaternion component after the optional conjugate, so +2.0 fits.
  typedef logic signed [16:0] comp_t;
  // Exact product of two components, Q6.28.
  typedef logic signed [33:0] prod_t;
  // Rotation coefficient, Q.28, holds 2*(ab +/- cd) without wrap.
  typedef logic signed [34:0] coef_t;
  // Coefficient times a vector component.
  typedef logic signed [50:0] term_t;
  // Sum of three terms.
  typedef logic signed [52:0] sum_t;

  localparam int unsigned FracBits = 28;
  localparam sum_t RoundHalf = sum_t'(1) <<< (FracBits - 1);
  localparam int unsigned RndW = $bits(sum_t) - FracBits;
  typedef logic signed [RndW-1:0] rnd_t;
  localparam rnd_t RotMax = rnd_t'(32767);
  localparam rnd_t RotMin = -rnd_t'(32768);

  typedef struct packed {
    vec_t quat_w;
    vec_t quat_x;
    vec_t quat_y;
    vec_t quat_z;
    vec_t vec_x;
    vec_t vec_y;
    vec_t vec_z;
    logic inverse;
  } in_t;

  typedef struct packed {
    prod_t w2;
    prod_t x2;
    prod_t y2;
    prod_t z2;
    prod_t wx;
    prod_t wy;
    prod_t wz;
    prod_t xy;
    prod_t xz;
    prod_t yz;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } prod_set_t;

  typedef struct packed {
    coef_t m00;
    coef_t m01;
    coef_t m02;
    coef_t m10;
    coef_t m11;
    coef_t m12;
    coef_t m20;
    coef_t m21;
    coef_t m22;
    vec_t  vec_x;
    vec_t  vec_y;
    vec_t  vec_z;
  } coef_set_t;

  typedef struct packed {
    vec_t rot_x;
    vec_t rot_y;
    vec_t rot_z;
    logic saturated;
  } out_t;

endpackage

`default_nettype wire

[hdl/qvr_if.sv]
`default_nettype none

interface qvr_in_if;
  logic valid;
  logic ready;
  logic signed [15:0] quat_w;
  logic signed [15:0] quat_x;
  logic signed [15:0] quat_y;
  logic signed [15:0] quat_z;
  logic signed [15:0] vec_x;
  logic signed [15:0] vec_y;
  logic signed [15:0] vec_z;
  logic inverse;

  modport source (
    output valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, inverse,
    input  ready
  );
  modport sink (
    input  valid, quat_w, quat_x, quat_y, quat_z, vec_x, vec_y, vec_z, inverse,
    output ready
  );
endinterface

interface qvr_out_if;
  logic valid;
  logic ready;
  logic signed [15:0] rot_x;
  logic signed [15:0] rot_y;
  logic signed [15:0] rot_z;
  logic saturated;

  modport source (
    output valid, rot_x, rot_y, rot_z, saturated,
    input  ready
  );
  modport sink (
    input  valid, rot_x, rot_y, rot_z, saturated,
    output ready
  );
endinterface

`default_nettype wire

[hdl/quaternion_vector_rotation_top.sv]
// Quaternion vector rotation.
//
// Input channel in_i: a quaternion (quat_w/x/y/z, signed Q2.14), a vector
// (vec_x/y/z, signed 16-bit) and the inverse flag, which rotates by the
// conjugate. Output channel out_o: the rotated vector rot_x/y/z, rounded
// to nearest (ties up) and clipped to signed 16 bits, and saturated, set
// when any component was clipped. The quaternion is not normalized, so a
// non-unit quaternion scales the vector by |q|^2.
//
// Both channels transfer when valid and ready are high at a rising edge.
// An input transfer reaches out_o through registered stages: products,
// coefficients, coefficient-by-vector multiplies, then sum/round/clip.
// Throughput is one item per cycle while out_o.ready is high; each stage
// holds one item and refills when empty or when its successor takes it.
//
// When the receiver stalls, the output register holds its result and the
// stages behind it fill up one by one; in_i.ready drops only once all
// four stages hold items. Nothing is dropped or repeated.
// Reset (rst_ni low, asynchronous) clears all valid bits; the data
// registers are not reset.
`default_nettype none

module quaternion_vector_rotation_top (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  qvr_in_if.sink      in_i,
  qvr_out_if.source   out_o
);
  import qvr_pkg::*;

  in_t       in_data;
  prod_set_t prod_data;
  coef_set_t coef_data;
  out_t      out_data;
  logic      prod_valid, prod_ready;
  logic      coef_valid, coef_ready;

  // Gather the input payload into one word.
  always_comb begin
    in_data.quat_w  = in_i.quat_w;
    in_data.quat_x  = in_i.quat_x;
    in_data.quat_y  = in_i.quat_y;
    in_data.quat_z  = in_i.quat_z;
    in_data.vec_x   = in_i.vec_x;
    in_data.vec_y   = in_i.vec_y;
    in_data.vec_z   = in_i.vec_z;
    in_data.inverse = in_i.inverse;
  end

  // Stage 1: conjugate and component products.
  qvr_prod u_prod (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_i.valid),
    .ready_o (in_i.ready),
    .data_i  (in_data),
    .valid_o (prod_valid),
    .ready_i (prod_ready),
    .data_o  (prod_data)
  );

  // Stage 2: rotation coefficients.
  qvr_coef u_coef (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (prod_valid),
    .ready_o (prod_ready),
    .data_i  (prod_data),
    .valid_o (coef_valid),
    .ready_i (coef_ready),
    .data_o  (coef_data)
  );

  // Stages 3 and 4: matrix-vector multiply, round and clip.
  qvr_mac u_mac (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (coef_valid),
    .ready_o (coef_ready),
    .data_i  (coef_data),
    .valid_o (out_o.valid),
    .ready_i (out_o.ready),
    .data_o  (out_data)
  );

  // Drive the output payload straight from the output register.
  assign out_o.rot_x     = out_data.rot_x;
  assign out_o.rot_y     = out_data.rot_y;
  assign out_o.rot_z     = out_data.rot_z;
  assign out_o.saturated = out_data.saturated;

endmodule

`default_nettype wire

[hdl/qvr_prod.sv]
`default_nettype none

// Stage 1: apply the conjugate and form the ten component products.
module qvr_prod (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               valid_i,
  output logic                    ready_o,
  input  wire qvr_pkg::in_t       data_i,
  output logic                    valid_o,
  input  wire logic               ready_i,
  output qvr_pkg::prod_set_t      data_o
);
  import qvr_pkg::*;

  comp_t     w, x, y, z;
  prod_set_t prod_d, prod_q;
  logic      valid_q;

  always_comb begin
    w = comp_t'(data_i.quat_w);
    x = comp_t'(data_i.quat_x);
    y = comp_t'(data_i.quat_y);
    z = comp_t'(data_i.quat_z);
    if (data_i.inverse) begin
      x = -x;
      y = -y;
      z = -z;
    end
    prod_d.w2    = w * w;
    prod_d.x2    = x * x;
    prod_d.y2    = y * y;
    prod_d.z2    = z * z;
    prod_d.wx    = w * x;
    prod_d.wy    = w * y;
    prod_d.wz    = w * z;
    prod_d.xy    = x * y;
    prod_d.xz    = x * z;
    prod_d.yz    = y * z;
    prod_d.vec_x = data_i.vec_x;
    prod_d.vec_y = data_i.vec_y;
    prod_d.vec_z = data_i.vec_z;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      prod_q <= prod_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = prod_q;

endmodule

`default_nettype wire

[hdl/qvr_coef.sv]
`default_nettype none

// Stage 2: combine products into the nine rotation coefficients.
module qvr_coef (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire qvr_pkg::prod_set_t  data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output qvr_pkg::coef_set_t       data_o
);
  import qvr_pkg::*;

  coef_set_t coef_d, coef_q;
  logic      valid_q;

  always_comb begin
    coef_d.m00   = coef_t'(data_i.w2) + coef_t'(data_i.x2) - coef_t'(data_i.y2)
                 - coef_t'(data_i.z2);
    coef_d.m11   = coef_t'(data_i.w2) - coef_t'(data_i.x2) + coef_t'(data_i.y2)
                 - coef_t'(data_i.z2);
    coef_d.m22   = coef_t'(data_i.w2) - coef_t'(data_i.x2) - coef_t'(data_i.y2)
                 + coef_t'(data_i.z2);
    coef_d.m01   = (coef_t'(data_i.xy) - coef_t'(data_i.wz)) <<< 1;
    coef_d.m02   = (coef_t'(data_i.wy) + coef_t'(data_i.xz)) <<< 1;
    coef_d.m10   = (coef_t'(data_i.xy) + coef_t'(data_i.wz)) <<< 1;
    coef_d.m12   = (coef_t'(data_i.yz) - coef_t'(data_i.wx)) <<< 1;
    coef_d.m20   = (coef_t'(data_i.xz) - coef_t'(data_i.wy)) <<< 1;
    coef_d.m21   = (coef_t'(data_i.wx) + coef_t'(data_i.yz)) <<< 1;
    coef_d.vec_x = data_i.vec_x;
    coef_d.vec_y = data_i.vec_y;
    coef_d.vec_z = data_i.vec_z;
  end

  assign ready_o = ~valid_q | ready_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (ready_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      coef_q <= coef_d;
    end
  end

  assign valid_o = valid_q;
  assign data_o  = coef_q;

endmodule

`default_nettype wire

[hdl/qvr_mac.sv]
`default_nettype none

// Stages 3 and 4: multiply coefficients by the vector, then sum, round
// and saturate each row.
module qvr_mac (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                valid_i,
  output logic                     ready_o,
  input  wire qvr_pkg::coef_set_t  data_i,
  output logic                     valid_o,
  input  wire logic                ready_i,
  output qvr_pkg::out_t            data_o
);
  import qvr_pkg::*;

  term_t t_d [9];
  term_t t_q [9];
  logic  mul_valid_q;
  logic  mul_ready;

  sum_t  sum [3];
  rnd_t  rnd [3];
  vec_t  clip [3];
  logic  [2:0] clipped;
  out_t  out_d, out_q;
  logic  out_valid_q;

  always_comb begin
    t_d[0] = data_i.m00 * data_i.vec_x;
    t_d[1] = data_i.m01 * data_i.vec_y;
    t_d[2] = data_i.m02 * data_i.vec_z;
    t_d[3] = data_i.m10 * data_i.vec_x;
    t_d[4] = data_i.m11 * data_i.vec_y;
    t_d[5] = data_i.m12 * data_i.vec_z;
    t_d[6] = data_i.m20 * data_i.vec_x;
    t_d[7] = data_i.m21 * data_i.vec_y;
    t_d[8] = data_i.m22 * data_i.vec_z;
  end

  assign mul_ready = ~out_valid_q | ready_i;
  assign ready_o   = ~mul_valid_q | mul_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_valid_q <= 1'b0;
    end else if (ready_o) begin
      mul_valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ready_o && valid_i) begin
      t_q <= t_d;
    end
  end

  // Round to nearest, ties toward plus infinity, then clip to 16 bits.
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      sum[r] = sum_t'(t_q[3*r]) + sum_t'(t_q[3*r+1]) + sum_t'(t_q[3*r+2]);
      rnd[r] = rnd_t'((sum[r] + RoundHalf) >>> FracBits);
      if (rnd[r] > RotMax) begin
        clip[r]    = vec_t'(RotMax);
        clipped[r] = 1'b1;
      end else if (rnd[r] < RotMin) begin
        clip[r]    = vec_t'(RotMin);
        clipped[r] = 1'b1;
      end else begin
        clip[r]    = vec_t'(rnd[r]);
        clipped[r] = 1'b0;
      end
    end
    out_d.rot_x     = clip[0];
    out_d.rot_y     = clip[1];
    out_d.rot_z     = clip[2];
    out_d.saturated = |clipped;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (mul_ready) begin
      out_valid_q <= mul_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mul_ready && mul_valid_q) begin
      out_q <= out_d;
    end
  end

  assign valid_o = out_valid_q;
  assign data_o  = out_q;

endmodule

`default_nettype wire

[hdl/qvr_checker.sv]
`default_nettype none

module qvr_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        in_valid_i,
  input wire logic        in_ready_i,
  input wire logic        out_valid_i,
  input wire logic        out_ready_i,
  input wire logic [15:0] rot_x_i,
  input wire logic [15:0] rot_y_i,
  input wire logic [15:0] rot_z_i,
  input wire logic        saturated_i
);

  // Input backs up only when every stage is full, so the output is valid.
  a_stall_only_when_full: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i
  ) else $error("input stalled while output empty");

  // A clipped result shows at least one component at a rail.
  a_sat_at_rail: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && saturated_i) |->
      (rot_x_i == 16'h7FFF || rot_x_i == 16'h8000 ||
       rot_y_i == 16'h7FFF || rot_y_i == 16'h8000 ||
       rot_z_i == 16'h7FFF || rot_z_i == 16'h8000)
  ) else $error("saturated set with no component at a rail");

  // Hold the result while the receiver stalls.
  a_out_hold: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (out_valid_i && !out_ready_i) |=>
      (out_valid_i && $stable(rot_x_i) && $stable(rot_y_i) &&
       $stable(rot_z_i) && $stable(saturated_i))
  ) else $error("output changed during stall");

  // An output that follows an empty pipeline comes from an earlier input transfer.
  a_min_latency: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (!out_valid_i && !(in_valid_i && in_ready_i)) |=> !out_valid_i ||
      $past(in_valid_i && in_ready_i, 4) || $past(in_valid_i && in_ready_i, 5) ||
      $past(in_valid_i && in_ready_i, 3) || $past(in_valid_i && in_ready_i, 2)
  ) else $error("output appeared without an earlier input transfer");

endmodule

bind quaternion_vector_rotation_top qvr_checker u_qvr_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .rot_x_i     (out_o.rot_x),
  .rot_y_i     (out_o.rot_y),
  .rot_z_i     (out_o.rot_z),
  .saturated_i (out_o.saturated)
);

`default_nettype wire
